### hdl/binary_to_decimal_ascii_unit_macros.svh
// assertion macros shared by the binary to decimal ascii unit
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/b2da_pkg.sv
// shared types and constants of the binary to decimal ascii unit
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = DIGITS * DIGIT_W;
    localparam int CHAR_W   = 6;
    localparam int CNT_W    = 5;
    localparam int DCNT_W   = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic convert;
        logic skip;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic conv_done;
        logic lead_zero;
        logic last_digit;
    } status_t;

endpackage

### hdl/binary_to_decimal_ascii_unit.sv
// top level of the binary to decimal ascii unit
`timescale 1ns / 1ps
// Converts an unsigned 32-bit value to decimal ascii characters.
// Input channel s_*: one transaction carries the value in s_tdata[31:0].
// Output channel m_*: one transaction per character, most significant digit
// first, leading zeros suppressed; a zero input gives a single '0'.
// m_tdata[5:0] holds the ascii code, m_tlast marks the least significant digit.
// Steps: the value is loaded in the accept cycle, then the bit-serial
// shift-add-3 loop builds ten bcd digits in one 40-bit register, then each
// leading zero is shifted out, then a check finds the first digit to send,
// then one output transaction follows per remaining digit.
// One item is handled at a time; s_tready is high only while idle.
// A stall on m_tready holds the current character and m_tlast steady and
// stretches the run by the stall length.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// m_tvalid; no other state is kept between items.
module binary_to_decimal_ascii_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [b2da_pkg::S_DATA_W-1:0]   s_tdata,   // [31:0] value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [b2da_pkg::M_DATA_W-1:0]   m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                            m_tlast    // last
);

    b2da_pkg::cmd_t                cmd;
    b2da_pkg::status_t             status;
    logic [b2da_pkg::CHAR_W-1:0]   digit_char;

    // controller
    b2da_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    b2da_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .value      (s_tdata[b2da_pkg::VALUE_W-1:0]),
        .status     (status),
        .digit_char (digit_char),
        .last       (m_tlast)
    );

    // pack the character into the byte-wide data bus
    assign m_tdata = {{(b2da_pkg::M_DATA_W - b2da_pkg::CHAR_W){1'b0}}, digit_char};

endmodule

### hdl/b2da_ctrl.sv
// controller state machine of the binary to decimal ascii unit
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_unit_macros.svh"

module b2da_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  b2da_pkg::status_t status,
    output b2da_pkg::cmd_t    cmd
);

    b2da_pkg::state_t state_reg;
    b2da_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = b2da_pkg::ST_CONVERT;
            end
            b2da_pkg::ST_CONVERT: begin
                if (status.conv_done) state_next = b2da_pkg::ST_SKIP;
            end
            b2da_pkg::ST_SKIP: begin
                if (!status.lead_zero) state_next = b2da_pkg::ST_EMIT;
            end
            b2da_pkg::ST_EMIT: begin
                if (m_tready && status.last_digit) state_next = b2da_pkg::ST_IDLE;
            end
            default: state_next = b2da_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            b2da_pkg::ST_CONVERT: begin
                cmd.convert = 1'b1;
            end
            b2da_pkg::ST_SKIP: begin
                cmd.skip = status.lead_zero;
            end
            b2da_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                cmd.emit = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    `B2DA_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while a result is offered")
    `B2DA_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == b2da_pkg::ST_CONVERT, "accepted transaction did not start conversion")
    `B2DA_ASSERT_NEXT(a_run_ends, m_tvalid && m_tready && status.last_digit, s_tready, "run did not end after last digit")

endmodule

### hdl/b2da_datapath.sv
// shift-add-3 conversion and digit emission datapath
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_unit_macros.svh"

module b2da_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  b2da_pkg::cmd_t                cmd,
    input  logic [b2da_pkg::VALUE_W-1:0]  value,
    output b2da_pkg::status_t             status,
    output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last
);

    logic [b2da_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [b2da_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [b2da_pkg::CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [b2da_pkg::DCNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic [b2da_pkg::BCD_W-1:0]   bcd_adj;
    logic [b2da_pkg::DIGIT_W-1:0] top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
            end
        end
    end

    // next values of the working registers
    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load) begin
            bin_next     = value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = b2da_pkg::DCNT_W'(b2da_pkg::DIGITS);
        end else if (cmd.convert) begin
            bin_next     = {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
            bcd_next     = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end else if (cmd.skip || cmd.emit) begin
            bcd_next     = {bcd_reg[b2da_pkg::BCD_W-b2da_pkg::DIGIT_W-1:0],
                            {b2da_pkg::DIGIT_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

    // status and result fields
    assign top_digit         = bcd_reg[b2da_pkg::BCD_W-1 -: b2da_pkg::DIGIT_W];
    assign status.conv_done  = (bit_cnt_reg == b2da_pkg::CNT_W'(b2da_pkg::VALUE_W - 1));
    assign status.last_digit = (dig_cnt_reg == b2da_pkg::DCNT_W'(1));
    assign status.lead_zero  = (top_digit == '0) && !status.last_digit;
    assign digit_char        = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
    assign last              = status.last_digit;

    `B2DA_ASSERT_NEXT(a_load_init, cmd.load, (bit_cnt_reg == '0) && (dig_cnt_reg == b2da_pkg::DCNT_W'(b2da_pkg::DIGITS)), "load did not reset counters")
    `B2DA_ASSERT_NOW(a_digit_range, cmd.emit, top_digit <= 4'd9, "emitted digit is not decimal")
    `B2DA_ASSERT_NOW(a_count_live, cmd.skip || cmd.emit, dig_cnt_reg != '0, "digit count ran out")

endmodule

### tb/binary_to_decimal_ascii_unit_test.sv
// self-checking testbench of the binary to decimal ascii unit
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_test;

    localparam int          CLK_HALF_NS    = 2;
    localparam int          RESET_CYCLES   = 8;
    localparam int unsigned RADIX          = 10;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          RANDOM_PER_RUN = 119;
    localparam time         RUN_LIMIT      = 4ms;

    // one expected character of the decimal text
    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last_flag;
    } decimal_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] digit_char, [7:6] zero
    logic        m_tlast;   // last

    decimal_char_t expected_chars[$];
    int unsigned   mismatch_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;

    binary_to_decimal_ascii_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // free-running clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // queue the decimal characters of one value, most significant first
    function automatic void predict_decimal_chars(input logic [b2da_pkg::VALUE_W-1:0] value);
        logic [b2da_pkg::VALUE_W-1:0] rest;
        logic [b2da_pkg::DIGIT_W-1:0] lsd_first[b2da_pkg::DIGITS];
        int                           count;
        decimal_char_t                ch;
        rest  = value;
        count = 0;
        do begin
            lsd_first[count] = b2da_pkg::DIGIT_W'(rest % RADIX);
            rest             = rest / RADIX;
            count++;
        end while (rest != 0 && count < b2da_pkg::DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            ch.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(lsd_first[k]);
            ch.last_flag  = (k == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // random value with a given number of decimal digits
    function automatic logic [b2da_pkg::VALUE_W-1:0] value_with_digits(input int digits);
        longint lo;
        longint hi;
        lo = 1;
        for (int i = 1; i < digits; i++) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (digits == 1) lo = 0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_decimal_chars(value);
        @(negedge aclk);
    endtask

    // receiver backpressure
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each output transaction with the oldest expected character
    always @(posedge aclk) begin
        decimal_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected character: expected none, actual %0d last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata[b2da_pkg::CHAR_W-1:0] !== want.digit_char) begin
                    mismatch_count++;
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, want.digit_char, m_tdata[b2da_pkg::CHAR_W-1:0]);
                end
                if (m_tlast !== want.last_flag) begin
                    mismatch_count++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last_flag, m_tlast);
                end
                if (m_tdata[7:b2da_pkg::CHAR_W] !== '0) begin
                    mismatch_count++;
                    $display("%0t: tdata padding mismatch: expected 0, actual %0b",
                             $time, m_tdata[7:b2da_pkg::CHAR_W]);
                end
            end
        end
    end

    // zero and the single-digit extremes
    task automatic test_zero_and_one_digit();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
    endtask

    // values on both sides of several changes in digit count
    task automatic test_digit_count_boundaries();
        send_value(32'd10);
        send_value(32'd11);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'd9999999);
        send_value(32'd10000000);
        send_value(32'd99999999);
        send_value(32'd100000000);
        send_value(32'd100000001);
        send_value(32'd999999999);
    endtask

    // ten-digit values up to the top of the range
    task automatic test_ten_digit_values();
        send_value(32'd1000000000);
        send_value(32'd1010101010);
        send_value(32'd1999999999);
        send_value(32'd2147483647);
        send_value(32'd2147483648);
        send_value(32'd4000000000);
        send_value(32'd4294967294);
        send_value(32'd4294967295);
    endtask

    // random values, mostly spread evenly over the digit counts
    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 7) send_value(value_with_digits($urandom_range(10, 1)));
            else                       send_value($urandom);
        end
    endtask

    // test sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        send_idle_pct  = 31;
        recv_idle_pct  = 76;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_zero_and_one_digit();
        test_digit_count_boundaries();
        test_ten_digit_values();
        test_random_values(RANDOM_PER_RUN);

        send_idle_pct = 76;
        recv_idle_pct = 31;
        test_random_values(RANDOM_PER_RUN);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_values(RANDOM_PER_RUN);

        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
